// ----- sv/kvlfp_pkg.sv -----
// Package for the key-value line flag parser.
// Holds the word types, status codes, character codes and match tables.
// No dependencies; used by key_value_line_flag_parser, kvlfp_line_checker and tb_top.
package kvlfp_pkg;

   localparam int COUNT_BITS = 16;
   localparam int KEY_COUNT = 3;
   localparam int WORD_COUNT = 8;
   localparam int TRUE_WORDS = 4;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       final_byte;
   } req_word_type;

   typedef struct packed {
      logic [1:0]            line_status;
      logic [1:0]            matched_key;
      logic                  parsed_value;
      logic                  flag_debugger;
      logic                  flag_tracing;
      logic                  flag_stack;
      logic [COUNT_BITS-1:0] applied_count;
      logic [COUNT_BITS-1:0] unknown_count;
      logic                  buffer_done;
   } rsp_word_type;

   localparam logic [1:0] STATUS_APPLIED   = 2'd0;
   localparam logic [1:0] STATUS_UNKNOWN   = 2'd1;
   localparam logic [1:0] STATUS_MALFORMED = 2'd2;
   localparam logic [1:0] STATUS_SKIPPED   = 2'd3;

   localparam logic [1:0] FIRST_NONE  = 2'd0;
   localparam logic [1:0] FIRST_OTHER = 2'd1;
   localparam logic [1:0] FIRST_HASH  = 2'd2;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // Strings are right-aligned: the last character sits in the low byte.
   // The keys are held as ASCII codes: the debugger, tracing and stack policy keys.
   localparam logic [191:0] KEY_TEXT [KEY_COUNT] = '{
      192'h69676e6f_72655f64_65627567_6765725f_70726573_656e74,
      192'h69676e6f_72655f65_7477,
      192'h66616b65_5f6f6b5f_73746163_6b5f6775_6172616e_746565
   };
   localparam logic [4:0] KEY_LEN [KEY_COUNT] = '{5'd23, 5'd10, 5'd23};

   localparam logic [47:0] WORD_TEXT [WORD_COUNT] = '{
      48'("1"), 48'("true"), 48'("yes"), 48'("on"),
      48'("0"), 48'("false"), 48'("no"), 48'("off")
   };
   localparam logic [2:0] WORD_LEN [WORD_COUNT] = '{
      3'd1, 3'd4, 3'd3, 3'd2, 3'd1, 3'd5, 3'd2, 3'd3
   };

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         return c + CASE_OFFSET;
      end
      return c;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   function automatic logic [7:0] key_char_at(input logic [1:0] idx, input logic [4:0] pos);
      logic [4:0]   off;
      logic [191:0] v;
      off = KEY_LEN[idx] - 5'd1 - pos;
      v = KEY_TEXT[idx] >> {off, 3'b000};
      return v[7:0];
   endfunction

   function automatic logic [7:0] word_char_at(input logic [2:0] idx, input logic [2:0] pos);
      logic [2:0]  off;
      logic [47:0] v;
      off = WORD_LEN[idx] - 3'd1 - pos;
      v = WORD_TEXT[idx] >> {off, 3'b000};
      return v[7:0];
   endfunction

endpackage

// ----- sv/key_value_line_flag_parser.sv -----
// A line end byte's result word is registered and is offered in the cycle after acceptance.
// Throughput: one byte per cycle while input is not held off; the parse state and match flags update in
// the same cycle, and a single result register carries the line result.
// Input is held off only while a result waits and the output is stalled.
// Reset (synchronous, active high) clears the parse state, the policy flags
// and both counters; the result register comes up empty.
module key_value_line_flag_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  kvlfp_pkg::req_word_type req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output kvlfp_pkg::rsp_word_type rsp_word
);
   import kvlfp_pkg::*;

   typedef enum logic [2:0] {
      PH_LEAD   = 3'd0,
      PH_IGNORE = 3'd1,
      PH_KEY    = 3'd2,
      PH_VLEAD  = 3'd3,
      PH_VALUE  = 3'd4
   } phase_type;

   localparam logic [4:0] KEY_POS_MAX = 5'd31;
   localparam logic [2:0] VALUE_POS_MAX = 3'd7;

   phase_type             phase_ff, phase_in;
   logic [4:0]            key_pos_ff, key_pos_in;
   logic [KEY_COUNT-1:0]  key_alive_ff, key_alive_in;
   logic [2:0]            value_pos_ff, value_pos_in;
   logic [WORD_COUNT-1:0] value_alive_ff, value_alive_in;
   logic                  pending_blank_ff, pending_blank_in;
   logic [1:0]            first_byte_ff, first_byte_in;
   logic [KEY_COUNT-1:0]  flags_ff, flags_in;
   logic [COUNT_BITS-1:0] applied_ff, applied_in;
   logic [COUNT_BITS-1:0] unknown_ff, unknown_in;
   logic                  rsp_valid_ff;
   rsp_word_type          rsp_word_ff;
   rsp_word_type          result;

   logic       accept;
   logic       line_end;
   logic [7:0] c;
   logic [7:0] fc;
   logic       key_found;
   logic [1:0] key_idx;
   logic       word_found;
   logic [2:0] word_idx;

   assign c         = req_word.text_byte;
   assign fc        = fold_case(c);
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign line_end  = (c == CH_LF) || req_word.final_byte;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      phase_in         = phase_ff;
      key_pos_in       = key_pos_ff;
      key_alive_in     = key_alive_ff;
      value_pos_in     = value_pos_ff;
      value_alive_in   = value_alive_ff;
      pending_blank_in = pending_blank_ff;
      first_byte_in    = first_byte_ff;
      flags_in         = flags_ff;
      applied_in       = applied_ff;
      unknown_in       = unknown_ff;
      key_found        = 1'b0;
      key_idx          = 2'd0;
      word_found       = 1'b0;
      word_idx         = 3'd0;
      result           = '0;

      if (c != CH_LF) begin
         if (first_byte_in == FIRST_NONE) begin
            first_byte_in = (c == CH_HASH) ? FIRST_HASH : FIRST_OTHER;
         end
         unique case (phase_ff)
            PH_LEAD: begin
               if (!is_blank(c)) begin
                  if (c == CH_HASH || c == CH_CR) begin
                     phase_in = PH_IGNORE;
                  end else if (c == CH_EQUALS) begin
                     phase_in = PH_VLEAD;
                  end else begin
                     phase_in = PH_KEY;
                     for (int i = 0; i < KEY_COUNT; i++) begin
                        if (key_pos_ff >= KEY_LEN[i] || key_char_at(2'(i), key_pos_ff) != fc) begin
                           key_alive_in[i] = 1'b0;
                        end
                     end
                     if (key_pos_ff < KEY_POS_MAX) key_pos_in = key_pos_ff + 5'd1;
                  end
               end
            end
            PH_KEY: begin
               if (c == CH_EQUALS) begin
                  phase_in = PH_VLEAD;
                  pending_blank_in = 1'b0;
               end else if (is_blank(c)) begin
                  pending_blank_in = 1'b1;
               end else begin
                  if (pending_blank_ff) key_alive_in = '0;
                  pending_blank_in = 1'b0;
                  for (int i = 0; i < KEY_COUNT; i++) begin
                     if (key_pos_ff >= KEY_LEN[i] || key_char_at(2'(i), key_pos_ff) != fc) begin
                        key_alive_in[i] = 1'b0;
                     end
                  end
                  if (key_pos_ff < KEY_POS_MAX) key_pos_in = key_pos_ff + 5'd1;
               end
            end
            PH_VLEAD, PH_VALUE: begin
               if (phase_ff == PH_VLEAD && is_blank(c)) begin
                  phase_in = PH_VLEAD;
               end else if (is_blank(c) || c == CH_CR) begin
                  phase_in = PH_VALUE;
                  pending_blank_in = 1'b1;
               end else begin
                  phase_in = PH_VALUE;
                  if (pending_blank_ff) value_alive_in = '0;
                  pending_blank_in = 1'b0;
                  for (int i = 0; i < WORD_COUNT; i++) begin
                     if (value_pos_ff >= WORD_LEN[i] ||
                         word_char_at(3'(i), value_pos_ff) != fc) begin
                        value_alive_in[i] = 1'b0;
                     end
                  end
                  if (value_pos_ff < VALUE_POS_MAX) value_pos_in = value_pos_ff + 3'd1;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end

      for (int i = KEY_COUNT - 1; i >= 0; i--) begin
         if (key_alive_in[i] && key_pos_in == KEY_LEN[i]) begin
            key_found = 1'b1;
            key_idx   = 2'(i);
         end
      end
      for (int i = WORD_COUNT - 1; i >= 0; i--) begin
         if (value_alive_in[i] && value_pos_in == WORD_LEN[i]) begin
            word_found = 1'b1;
            word_idx   = 3'(i);
         end
      end

      result.line_status = STATUS_SKIPPED;
      if (line_end) begin
         if (phase_in == PH_LEAD || phase_in == PH_IGNORE) begin
            if (first_byte_in == FIRST_OTHER) begin
               result.line_status = STATUS_UNKNOWN;
               if (unknown_ff != '1) unknown_in = unknown_ff + 1'b1;
            end
         end else if (phase_in == PH_KEY) begin
            result.line_status = STATUS_MALFORMED;
         end else if (!key_found) begin
            result.line_status = STATUS_UNKNOWN;
            if (unknown_ff != '1) unknown_in = unknown_ff + 1'b1;
         end else if (!word_found) begin
            result.line_status = STATUS_MALFORMED;
         end else begin
            result.line_status  = STATUS_APPLIED;
            result.matched_key  = key_idx;
            result.parsed_value = (word_idx < 3'(TRUE_WORDS));
            flags_in[key_idx]   = result.parsed_value;
            if (applied_ff != '1) applied_in = applied_ff + 1'b1;
         end
         phase_in         = PH_LEAD;
         key_pos_in       = '0;
         key_alive_in     = '1;
         value_pos_in     = '0;
         value_alive_in   = '1;
         pending_blank_in = 1'b0;
         first_byte_in    = FIRST_NONE;
      end
      result.flag_debugger = flags_in[0];
      result.flag_tracing  = flags_in[1];
      result.flag_stack    = flags_in[2];
      result.applied_count = applied_in;
      result.unknown_count = unknown_in;
      result.buffer_done   = req_word.final_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_LEAD;
         key_pos_ff       <= '0;
         key_alive_ff     <= '1;
         value_pos_ff     <= '0;
         value_alive_ff   <= '1;
         pending_blank_ff <= 1'b0;
         first_byte_ff    <= FIRST_NONE;
         flags_ff         <= '0;
         applied_ff       <= '0;
         unknown_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff         <= phase_in;
            key_pos_ff       <= key_pos_in;
            key_alive_ff     <= key_alive_in;
            value_pos_ff     <= value_pos_in;
            value_alive_ff   <= value_alive_in;
            pending_blank_ff <= pending_blank_in;
            first_byte_ff    <= first_byte_in;
            flags_ff         <= flags_in;
            applied_ff       <= applied_in;
            unknown_ff       <= unknown_in;
         end
         if (accept && line_end) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept && line_end) begin
         rsp_word_ff <= result;
      end
   end

   // The applied counter never goes backward outside reset.
   assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> applied_ff >= $past(applied_ff))
      else $error("applied count decreased");

   // Every accepted line end leaves the parser at the start of a fresh line.
   assert property (@(posedge clock) disable iff (reset)
      accept && line_end |=> phase_ff == PH_LEAD && first_byte_ff == FIRST_NONE)
      else $error("line state not cleared at line end");

   // An applied result reports the flag it just wrote.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.line_status == STATUS_APPLIED |->
         ((rsp_word_ff.matched_key == 2'd0 &&
           rsp_word_ff.flag_debugger == rsp_word_ff.parsed_value) ||
          (rsp_word_ff.matched_key == 2'd1 &&
           rsp_word_ff.flag_tracing == rsp_word_ff.parsed_value) ||
          (rsp_word_ff.matched_key == 2'd2 &&
           rsp_word_ff.flag_stack == rsp_word_ff.parsed_value)))
      else $error("applied flag mismatch");

endmodule

// ----- tb/kvlfp_line_checker.sv -----
`timescale 1ns / 100ps
// Line checker for the key-value line flag parser: watches both channels,
// predicts each line result word and compares it. Depends on kvlfp_pkg.
module kvlfp_line_checker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  kvlfp_pkg::req_word_type req_word,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  kvlfp_pkg::rsp_word_type rsp_word,
   output int                      mismatches,
   output int                      lines_in_flight
);
   import kvlfp_pkg::*;

   typedef enum logic [2:0] {
      SCAN_LEAD, SCAN_IGNORE, SCAN_KEY, SCAN_VALUE_LEAD, SCAN_VALUE
   } scan_phase_type;

   localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;
   localparam int KEY_POS_CAP = 31;
   localparam int WORD_POS_CAP = 7;

   string key_names [KEY_COUNT];
   string word_names [WORD_COUNT];

   scan_phase_type        phase;
   int                    key_pos;
   int                    word_pos;
   logic [KEY_COUNT-1:0]  key_live;
   logic [WORD_COUNT-1:0] word_live;
   logic                  gap_seen;
   logic [1:0]            first_kind;
   logic [KEY_COUNT-1:0]  flags;
   int                    applied_n;
   int                    unknown_n;
   rsp_word_type          expected_lines [$];

   function automatic string key_string(input int idx);
      string s;
      s = "";
      for (int p = 0; p < int'(KEY_LEN[idx]); p++) begin
         s = $sformatf("%s%c", s, key_char_at(2'(idx), 5'(p)));
      end
      return s;
   endfunction

   initial begin
      for (int i = 0; i < KEY_COUNT; i++) begin
         key_names[i] = key_string(i);
      end
      word_names[0] = "1";
      word_names[1] = "true";
      word_names[2] = "yes";
      word_names[3] = "on";
      word_names[4] = "0";
      word_names[5] = "false";
      word_names[6] = "no";
      word_names[7] = "off";
   end

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
   endfunction

   function automatic logic is_space_or_tab(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t line checker: %s", $time, what);
   endtask

   task automatic start_line();
      phase = SCAN_LEAD;
      key_pos = 0;
      key_live = '1;
      word_pos = 0;
      word_live = '1;
      gap_seen = 1'b0;
      first_kind = FIRST_NONE;
   endtask

   task automatic take_key_char(input logic [7:0] c);
      logic [7:0] ref_ch;
      if (gap_seen) begin
         key_live = '0;
      end
      gap_seen = 1'b0;
      for (int i = 0; i < KEY_COUNT; i++) begin
         if (key_pos >= key_names[i].len()) begin
            key_live[i] = 1'b0;
         end else begin
            ref_ch = key_names[i][key_pos];
            if (ref_ch != to_lower(c)) begin
               key_live[i] = 1'b0;
            end
         end
      end
      if (key_pos < KEY_POS_CAP) begin
         key_pos++;
      end
   endtask

   task automatic take_word_char(input logic [7:0] c);
      logic [7:0] ref_ch;
      if (gap_seen) begin
         word_live = '0;
      end
      gap_seen = 1'b0;
      for (int i = 0; i < WORD_COUNT; i++) begin
         if (word_pos >= word_names[i].len()) begin
            word_live[i] = 1'b0;
         end else begin
            ref_ch = word_names[i][word_pos];
            if (ref_ch != to_lower(c)) begin
               word_live[i] = 1'b0;
            end
         end
      end
      if (word_pos < WORD_POS_CAP) begin
         word_pos++;
      end
   endtask

   task automatic scan_byte(input logic [7:0] c);
      if (first_kind == FIRST_NONE) begin
         first_kind = (c == CH_HASH) ? FIRST_HASH : FIRST_OTHER;
      end
      case (phase)
         SCAN_LEAD: begin
            if (!is_space_or_tab(c)) begin
               if (c == CH_HASH || c == CH_CR) begin
                  phase = SCAN_IGNORE;
               end else if (c == CH_EQUALS) begin
                  phase = SCAN_VALUE_LEAD;
               end else begin
                  phase = SCAN_KEY;
                  take_key_char(c);
               end
            end
         end
         SCAN_KEY: begin
            if (c == CH_EQUALS) begin
               phase = SCAN_VALUE_LEAD;
               gap_seen = 1'b0;
            end else if (is_space_or_tab(c)) begin
               gap_seen = 1'b1;
            end else begin
               take_key_char(c);
            end
         end
         SCAN_VALUE_LEAD: begin
            if (!is_space_or_tab(c)) begin
               phase = SCAN_VALUE;
               if (c == CH_CR) begin
                  gap_seen = 1'b1;
               end else begin
                  take_word_char(c);
               end
            end
         end
         SCAN_VALUE: begin
            if (is_space_or_tab(c) || c == CH_CR) begin
               gap_seen = 1'b1;
            end else begin
               take_word_char(c);
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic close_line(input logic fin);
      rsp_word_type w;
      int           hit_key;
      int           hit_word;
      w = '0;
      w.line_status = STATUS_SKIPPED;
      hit_key = -1;
      hit_word = -1;
      if (phase == SCAN_LEAD || phase == SCAN_IGNORE) begin
         if (first_kind == FIRST_OTHER) begin
            w.line_status = STATUS_UNKNOWN;
            if (unknown_n < COUNT_MAX) unknown_n++;
         end
      end else if (phase == SCAN_KEY) begin
         w.line_status = STATUS_MALFORMED;
      end else begin
         for (int i = 0; i < KEY_COUNT; i++) begin
            if (hit_key < 0 && key_live[i] && key_pos == key_names[i].len()) begin
               hit_key = i;
            end
         end
         if (hit_key < 0) begin
            w.line_status = STATUS_UNKNOWN;
            if (unknown_n < COUNT_MAX) unknown_n++;
         end else begin
            for (int i = 0; i < WORD_COUNT; i++) begin
               if (hit_word < 0 && word_live[i] && word_pos == word_names[i].len()) begin
                  hit_word = i;
               end
            end
            if (hit_word < 0) begin
               w.line_status = STATUS_MALFORMED;
            end else begin
               w.line_status = STATUS_APPLIED;
               w.matched_key = hit_key[1:0];
               w.parsed_value = (hit_word < TRUE_WORDS);
               flags[hit_key] = w.parsed_value;
               if (applied_n < COUNT_MAX) applied_n++;
            end
         end
      end
      w.flag_debugger = flags[0];
      w.flag_tracing = flags[1];
      w.flag_stack = flags[2];
      w.applied_count = applied_n[COUNT_BITS-1:0];
      w.unknown_count = unknown_n[COUNT_BITS-1:0];
      w.buffer_done = fin;
      expected_lines.push_back(w);
      start_line();
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         start_line();
         flags = '0;
         applied_n = 0;
         unknown_n = 0;
         expected_lines.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_lines.size() == 0) begin
               report_mismatch("result word with no line pending");
            end else begin
               want = expected_lines.pop_front();
               if (rsp_word !== want) begin
                  report_mismatch($sformatf("result word %p, expected %p", rsp_word, want));
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_word.text_byte != CH_LF) begin
               scan_byte(req_word.text_byte);
            end
            if (req_word.text_byte == CH_LF || req_word.final_byte) begin
               close_line(req_word.final_byte);
            end
         end
      end
      lines_in_flight <= expected_lines.size();
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the key-value line flag parser testbench: clock, reset, text stimulus,
// result stalls and the verdict. Depends on kvlfp_pkg, key_value_line_flag_parser and kvlfp_line_checker.
module tb_top;
   import kvlfp_pkg::*;

   localparam int RANDOM_BYTES = 1650;
   localparam int LONG_HOLD = 300;
   localparam logic [7:0] LOWER_A = 8'h61;
   localparam logic [7:0] LOWER_Z = 8'h7A;
   localparam logic [7:0] PRINT_LOW = 8'h20;
   localparam logic [7:0] PRINT_HIGH = 8'h7E;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   int   mismatches;
   int   lines_in_flight;
   logic steady = 1'b0;
   logic hold_toggle = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_left;
   int   wait_left;
   int   sent_bytes;

   string        key_words [KEY_COUNT];
   string        bool_words [WORD_COUNT];
   string        bad_words [6];
   req_word_type line_words [$];

   key_value_line_flag_parser uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word)
   );

   kvlfp_line_checker watch (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .mismatches(mismatches),
      .lines_in_flight(lines_in_flight)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #50_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
         wait_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            wait_left = steady ? 0 : $urandom_range(0, 12);
         end
         if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic string key_string(input int idx);
      string s;
      s = "";
      for (int p = 0; p < int'(KEY_LEN[idx]); p++) begin
         s = $sformatf("%s%c", s, key_char_at(2'(idx), 5'(p)));
      end
      return s;
   endfunction

   task automatic send_byte(input req_word_type w);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_bytes++;
   endtask

   task automatic send_line();
      foreach (line_words[i]) begin
         send_byte(line_words[i]);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (lines_in_flight != 0) @(posedge clock);
   endtask

   task automatic add_byte(input logic [7:0] c, input logic fin);
      req_word_type w;
      w.text_byte = c;
      w.final_byte = fin;
      line_words.push_back(w);
   endtask

   task automatic add_text(input string s, input bit mixed);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (mixed && c >= LOWER_A && c <= LOWER_Z && $urandom_range(0, 2) == 0) begin
            c = c - CASE_OFFSET;
         end
         add_byte(c, 1'b0);
      end
   endtask

   task automatic add_blanks(input int most);
      int n;
      n = $urandom_range(0, most);
      repeat (n) add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
   endtask

   task automatic add_tail();
      int n;
      int pick;
      n = $urandom_range(0, 2);
      repeat (n) begin
         pick = $urandom_range(0, 2);
         add_byte(pick == 0 ? CH_SPACE : (pick == 1 ? CH_TAB : CH_CR), 1'b0);
      end
   endtask

   task automatic add_letters(input int low, input int high);
      int n;
      n = $urandom_range(low, high);
      repeat (n) add_byte(8'(LOWER_A + $urandom_range(0, 25)), 1'b0);
   endtask

   task automatic add_printable(input int most);
      int n;
      n = $urandom_range(0, most);
      repeat (n) add_byte(8'($urandom_range(PRINT_LOW, PRINT_HIGH)), 1'b0);
   endtask

   task automatic mark_last_final();
      req_word_type w;
      w = line_words.pop_back();
      w.final_byte = 1'b1;
      line_words.push_back(w);
   endtask

   task automatic run_text(input string s, input bit fin_last);
      line_words.delete();
      add_text(s, 0);
      if (fin_last) mark_last_final();
      send_line();
   endtask

   task automatic add_key_value_line();
      string        key_s;
      string        word_s;
      int           flaw;
      int           start;
      int           pos;
      req_word_type w;
      key_s = key_words[$urandom_range(0, KEY_COUNT - 1)];
      word_s = bool_words[$urandom_range(0, WORD_COUNT - 1)];
      flaw = $urandom_range(0, 11);
      add_blanks(2);
      start = line_words.size();
      if (flaw == 1) key_s = key_s.substr(0, key_s.len() - 2);
      if (flaw == 2) begin
         pos = $urandom_range(1, key_s.len() - 1);
         add_text(key_s.substr(0, pos - 1), 1);
         add_byte(CH_SPACE, 1'b0);
         add_text(key_s.substr(pos, key_s.len() - 1), 1);
      end else begin
         add_text(key_s, 1);
      end
      if (flaw == 0) begin
         pos = start + $urandom_range(0, key_s.len() - 1);
         w = line_words[pos];
         w.text_byte = 8'(LOWER_A + $urandom_range(0, 25));
         line_words[pos] = w;
      end
      if (flaw == 6) add_letters(1, 1);
      add_blanks(2);
      add_byte(CH_EQUALS, 1'b0);
      add_blanks(2);
      if (flaw == 3) word_s = bad_words[$urandom_range(0, 5)];
      if (flaw == 4) word_s = "";
      if (flaw == 5 && word_s.len() > 1) begin
         add_text(word_s.substr(0, 0), 1);
         add_byte($urandom_range(0, 1) ? CH_SPACE : CH_CR, 1'b0);
         add_text(word_s.substr(1, word_s.len() - 1), 1);
      end else begin
         add_text(word_s, 1);
      end
      add_tail();
   endtask

   task automatic make_line();
      int kind;
      int n;
      int ending;
      line_words.delete();
      kind = $urandom_range(0, 19);
      case (kind)
         10, 11: begin
            add_blanks(1);
            add_letters(1, 8);
            add_blanks(1);
            add_byte(CH_EQUALS, 1'b0);
            add_blanks(1);
            add_text(bool_words[$urandom_range(0, WORD_COUNT - 1)], 1);
         end
         12: begin
            add_blanks(1);
            add_text(key_words[$urandom_range(0, KEY_COUNT - 1)], 1);
            add_tail();
         end
         13: begin
            add_byte(CH_HASH, 1'b0);
            add_printable(6);
         end
         14: begin
            add_blanks(2);
            add_byte($urandom_range(0, 1) ? CH_HASH : CH_CR, 1'b0);
            add_printable(3);
         end
         15: add_blanks(3);
         16: begin
            add_blanks(1);
            add_byte(CH_EQUALS, 1'b0);
            add_blanks(1);
            add_text(bool_words[$urandom_range(0, WORD_COUNT - 1)], 1);
         end
         17, 18: begin
            n = $urandom_range(1, 12);
            repeat (n) add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
         end
         19: begin
            add_text(key_words[$urandom_range(0, KEY_COUNT - 1)], 1);
            add_byte(CH_EQUALS, 1'b0);
            add_text(bool_words[$urandom_range(0, WORD_COUNT - 1)], 1);
            add_byte(CH_CR, 1'b0);
            add_letters(1, 2);
         end
         default: add_key_value_line();
      endcase
      ending = $urandom_range(0, 9);
      if (ending <= 6) begin
         add_byte(CH_LF, 1'b0);
      end else if (ending == 7 || line_words.size() == 0) begin
         add_byte(CH_LF, 1'b1);
      end else begin
         mark_last_final();
      end
   endtask

   initial begin
      int line_no;
      int steady_lines;
      int stop_at;
      for (int i = 0; i < KEY_COUNT; i++) begin
         key_words[i] = key_string(i);
      end
      bool_words[0] = "1";
      bool_words[1] = "true";
      bool_words[2] = "yes";
      bool_words[3] = "on";
      bool_words[4] = "0";
      bool_words[5] = "false";
      bool_words[6] = "no";
      bool_words[7] = "off";
      bad_words[0] = "tru";
      bad_words[1] = "yess";
      bad_words[2] = "2";
      bad_words[3] = "onn";
      bad_words[4] = "of";
      bad_words[5] = "nope";
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_word <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      run_text("\n", 0);
      run_text(" \t\n", 0);
      run_text("#x\n", 0);
      run_text("\r\n", 0);
      run_text(" #\n", 0);
      run_text("=1\n", 0);
      run_text("ab\n", 0);
      line_words.delete();
      add_byte(8'hFF, 1'b1);
      add_byte(8'h00, 1'b0);
      add_byte(CH_LF, 1'b1);
      send_line();
      wait_drained();

      line_no = 0;
      steady_lines = 0;
      stop_at = sent_bytes + RANDOM_BYTES;
      while (sent_bytes < stop_at) begin
         if (line_no == 12 || $urandom_range(0, 59) == 0) begin
            hold_toggle <= ~hold_toggle;
            steady_lines = 10;
         end else if ($urandom_range(0, 9) == 0) begin
            steady_lines = $urandom_range(2, 6);
         end
         if (line_no == 30 || $urandom_range(0, 59) == 0) begin
            wait_drained();
         end
         steady <= (steady_lines > 0);
         if (steady_lines > 0) steady_lines--;
         make_line();
         send_line();
         line_no++;
      end
      wait_drained();

      steady <= 1'b0;
      repeat (12) begin
         make_line();
         send_line();
      end
      wait_drained();

      repeat (20) @(posedge clock);
      if (mismatches == 0 && lines_in_flight == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
